FILE: rtl/core/ipcwm_pkg.sv
// ----------------------------------------------------------------------------
// ipcwm_pkg
// Shared types and constants of the IPv4 CIDR whitelist match table.
// ----------------------------------------------------------------------------
package ipcwm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int CFG_W    = 7;
  localparam int SLOT_W   = 6;
  localparam int ADDR_W   = 32;
  localparam int LENGTH_W = 6;

  typedef enum logic [0:0] {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef struct packed {
    func_e               func;
    logic [SLOT_W-1:0]   entry_index;
    logic [ADDR_W-1:0]   entry_prefix;
    logic [LENGTH_W-1:0] entry_length;
    logic                entry_valid;
    logic [ADDR_W-1:0]   lookup_addr;
  } req_t;

  typedef struct packed {
    logic              allowed;
    logic [SLOT_W-1:0] first_match_index;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   prefix;
    logic [LENGTH_W-1:0] length;
  } entry_t;

endpackage

FILE: rtl/core/ipv4_cidr_whitelist_match_top.sv
// ----------------------------------------------------------------------------
// ipv4_cidr_whitelist_match_top
// Prefix table of IPv4 networks with a first-match lookup over a single-port
// entry memory.
//
//   channel   signals                      handshake
//   request   req_i (ipcwm_pkg::req_t)     start high, busy low
//   result    res_o (ipcwm_pkg::res_t)     done_o strobe, one cycle
//   config    cfg_wdata_i                  cfg_we_i
//
// A write item gives no result. A lookup keeps busy high while it reads
// entries, up to the first match or the last entry in use; the memory read
// port walks one entry a cycle. The result strobe follows in the next cycle;
// with no entries in use it comes right after the accept. Reset clears the
// valid bits at once, so no clearing pass is needed. The result side cannot
// stall.
// ----------------------------------------------------------------------------
module ipv4_cidr_whitelist_match_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  ipcwm_pkg::req_t                 req_i,
  output logic                            done_o,
  output ipcwm_pkg::res_t                 res_o,
  input  logic                            cfg_we_i,
  input  logic [ipcwm_pkg::CFG_W-1:0]     cfg_wdata_i
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  localparam int IW = ipcwm_pkg::IDX_W;

  state_e                          state_q;
  logic                            done_q;
  ipcwm_pkg::res_t                 res_q;
  logic [ipcwm_pkg::CFG_W-1:0]     cfg_q;
  logic [ipcwm_pkg::TABLE_DEPTH-1:0] vld_q;
  logic [IW-1:0]                   cur_q;
  logic [IW-1:0]                   last_q;
  logic [ipcwm_pkg::ADDR_W-1:0]    addr_q;
  logic                            rvld_q;

  ipcwm_pkg::entry_t               mem [ipcwm_pkg::TABLE_DEPTH];
  ipcwm_pkg::entry_t               ent_q;

  logic                            accept;
  logic                            wr_ok;
  logic [IW-1:0]                   wr_idx;
  logic                            mem_we;
  logic                            mem_re;
  logic [IW-1:0]                   rd_addr;
  logic [IW-1:0]                   next_idx;
  logic [ipcwm_pkg::ADDR_W-1:0]    mask;
  logic                            hit;
  logic                            finish;
  logic [IW-1:0]                   last_d;

  assign accept   = start && (state_q == ST_IDLE);
  assign wr_ok    = 32'(req_i.entry_index) < 32'(ipcwm_pkg::TABLE_DEPTH);
  assign wr_idx   = IW'(req_i.entry_index);
  assign mem_we   = accept && (req_i.func == ipcwm_pkg::FUNC_WRITE) && wr_ok;
  assign next_idx = IW'(cur_q + 1'b1);

  assign mask   = ~({ipcwm_pkg::ADDR_W{1'b1}} >> ent_q.length);
  assign hit    = rvld_q && (((addr_q ^ ent_q.prefix) & mask) == '0);
  assign finish = hit || (cur_q == last_q);

  assign mem_re  = (accept && (req_i.func == ipcwm_pkg::FUNC_LOOKUP)) ||
                   ((state_q == ST_SCAN) && !finish);
  assign rd_addr = (state_q == ST_IDLE) ? '0 : next_idx;

  always_comb begin
    if (32'(cfg_q) > 32'(ipcwm_pkg::TABLE_DEPTH)) begin
      last_d = IW'(ipcwm_pkg::TABLE_DEPTH - 1);
    end else begin
      last_d = IW'(cfg_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= '{prefix: req_i.entry_prefix, length: req_i.entry_length};
    end
    if (mem_re) begin
      ent_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
      cfg_q   <= '0;
      vld_q   <= '0;
      cur_q   <= '0;
      last_q  <= '0;
      addr_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            if (req_i.func == ipcwm_pkg::FUNC_WRITE) begin
              if (wr_ok) begin
                vld_q[wr_idx] <= req_i.entry_valid;
              end
            end else begin
              addr_q <= req_i.lookup_addr;
              cur_q  <= '0;
              last_q <= last_d;
              rvld_q <= vld_q[0];
              if (cfg_q == '0) begin
                done_q <= 1'b1;
                res_q  <= '0;
              end else begin
                state_q <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (finish) begin
            done_q                  <= 1'b1;
            res_q.allowed           <= hit;
            res_q.first_match_index <= hit ? ipcwm_pkg::SLOT_W'(cur_q) : '0;
            state_q                 <= ST_IDLE;
          end else begin
            cur_q  <= next_idx;
            rvld_q <= vld_q[next_idx];
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state_q == ST_SCAN);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/core/ipcwm_checker.sv
// ----------------------------------------------------------------------------
// ipcwm_checker
// Port-level checks of the whitelist match table, bound to the top level.
// ----------------------------------------------------------------------------
module ipcwm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input ipcwm_pkg::req_t req_i,
  input logic            done_o,
  input ipcwm_pkg::res_t res_o
);

  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.allowed) |-> (res_o.first_match_index == '0))
    else $error("miss reports a nonzero index");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.func == ipcwm_pkg::FUNC_WRITE)) |=> !done_o)
    else $error("write item produced a result");

  a_lookup_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.func == ipcwm_pkg::FUNC_LOOKUP)) |=> (busy || done_o))
    else $error("lookup item neither scanning nor done");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_scan_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("scan ended without a result");

endmodule

bind ipv4_cidr_whitelist_match_top ipcwm_checker u_ipcwm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .res_o  (res_o)
);
